@@ src/drtm_pkg.sv @@
package drtm_pkg;

    // Table geometry.
    localparam int MAX_OBJECTS = 64;
    localparam int IDX_W       = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
    localparam int CNT_W       = $clog2(MAX_OBJECTS + 1);

    // Field widths.
    localparam int OP_W       = 2;
    localparam int PT_W       = 16;
    localparam int ETA_W      = 17;
    localparam int PHI_W      = 16;
    localparam int DR_W       = 32;
    localparam int REL_W      = 12;
    localparam int OUT_IDX_W  = 6;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    // Datapath widths.
    localparam int ADE_SQ_W = 2 * ETA_W;
    localparam int ADP_SQ_W = 2 * PHI_W;
    localparam int DR_SUM_W = ADE_SQ_W + 1;
    localparam int LIM_W    = REL_W + PT_W;
    localparam int DPT_SH_W = PT_W + 4;

    localparam logic [DR_W-1:0]  RESET_MAX_DR_SQ   = 32'd10878;
    localparam logic [REL_W-1:0] RESET_MAX_REL_DPT = 12'd32;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_DR_SQ   = 4'd0,
        REG_MAX_REL_DPT = 4'd1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic [PT_W-1:0]  pt;
        logic [ETA_W-1:0] eta;
        logic [PHI_W-1:0] phi;
    } entry_t;

    // Slot number as reported on the result: the low six bits of the slot.
    function automatic logic [OUT_IDX_W-1:0] to_match_index(input logic [IDX_W-1:0] slot);
        logic [IDX_W+OUT_IDX_W-1:0] ext;
        ext = {{OUT_IDX_W{1'b0}}, slot};
        return ext[OUT_IDX_W-1:0];
    endfunction

endpackage

@@ src/drtm_if.sv @@
interface drtm_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [drtm_pkg::OP_W-1:0]            op;
    logic [drtm_pkg::PT_W-1:0]            pt;
    logic signed [drtm_pkg::ETA_W-1:0]    eta;
    logic signed [drtm_pkg::PHI_W-1:0]    phi;

    modport source (output valid, output op, output pt, output eta, output phi, input ready);
    modport sink   (input valid, input op, input pt, input eta, input phi, output ready);
endinterface

interface drtm_out_if;
    logic                               valid;
    logic                               ready;
    logic                               matched;
    logic [drtm_pkg::OUT_IDX_W-1:0]     match_index;
    logic [drtm_pkg::DR_W-1:0]          match_dr_sq;
    logic                               table_full;

    modport source (output valid, output matched, output match_index, output match_dr_sq,
                    output table_full, input ready);
    modport sink   (input valid, input matched, input match_index, input match_dr_sq,
                    input table_full, output ready);
endinterface

interface drtm_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [drtm_pkg::CFG_IDX_W-1:0]     index;
    logic [drtm_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/delta_r_trigger_match_unit.sv @@
// Nearest reference-object matcher on the delta-R metric. Load beats (op 0) append a
// reference object to a table of MAX_OBJECTS slots, clear beats (op 2) empty it, and query
// beats (op 1) scan the filled slots in order and return the slot with the smallest
// squared angular distance among those that pass both the relative pt cut and the
// distance limit; the lowest slot wins a tie. Every request beat yields exactly one
// response beat. A query is handled by one shared per-entry datapath fed from the
// table memory at one slot per cycle; it holds the block until every filled slot
// has been read and the scan pipeline has drained, then hands its result to the
// response register. A load, a clear or an unused op goes straight to the result
// state. The request side is ready only between items, while the response register
// lets a finished result wait for the consumer without holding up the next request.
// Configuration writes are always taken and should arrive only when the block is idle.
module delta_r_trigger_match_unit (
    input  logic              clk,
    input  logic              rst_n,
    drtm_cfg_if.sink          cfg,
    drtm_in_if.sink           req,
    drtm_out_if.source        rsp
);

    // Sequencer state and configuration.
    drtm_pkg::state_t                   state_reg, state_next;
    logic [drtm_pkg::DR_W-1:0]          max_dr_sq_reg, max_dr_sq_next;
    logic [drtm_pkg::REL_W-1:0]         max_rel_dpt_reg, max_rel_dpt_next;
    logic [drtm_pkg::CNT_W-1:0]         ref_count_reg, ref_count_next;
    logic [drtm_pkg::CNT_W-1:0]         issue_idx_reg, issue_idx_next;

    // Captured query fields.
    logic [drtm_pkg::PT_W-1:0]          q_pt_reg;
    logic [drtm_pkg::ETA_W-1:0]         q_eta_reg;
    logic [drtm_pkg::PHI_W-1:0]         q_phi_reg;

    // Reference table.
    drtm_pkg::entry_t                   mem [drtm_pkg::MAX_OBJECTS];
    drtm_pkg::entry_t                   rd_data_reg;

    // Scan pipeline.
    logic                               s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg;
    logic [drtm_pkg::IDX_W-1:0]         s1_idx_reg, s2_idx_reg, s3_idx_reg, s4_idx_reg;
    logic [drtm_pkg::ETA_W-1:0]         s2_ade_reg, s2_ade_next;
    logic [drtm_pkg::PHI_W-1:0]         s2_adp_reg, s2_adp_next;
    logic [drtm_pkg::PT_W-1:0]          s2_dpt_reg, s2_dpt_next;
    logic [drtm_pkg::PT_W-1:0]          s2_rp_reg;
    logic [drtm_pkg::ADE_SQ_W-1:0]      s3_ade_sq_reg, s3_ade_sq_next;
    logic [drtm_pkg::ADP_SQ_W-1:0]      s3_adp_sq_reg, s3_adp_sq_next;
    logic [drtm_pkg::DPT_SH_W-1:0]      s3_dpt16_reg, s3_dpt16_next;
    logic [drtm_pkg::LIM_W-1:0]         s3_lim_reg, s3_lim_next;
    logic [drtm_pkg::DR_SUM_W-1:0]      s4_dr_reg, s4_dr_next;
    logic                               s4_ok_reg, s4_ok_next;

    // Pending result: running best during a scan, or the answer to a load or clear.
    logic                               found_reg, found_next;
    logic [drtm_pkg::IDX_W-1:0]         best_idx_reg, best_idx_next;
    logic [drtm_pkg::DR_SUM_W-1:0]      best_dr_reg, best_dr_next;
    logic                               full_reg, full_next;

    // Response register.
    logic                               out_valid_reg, out_valid_next;
    logic                               out_matched_reg;
    logic [drtm_pkg::OUT_IDX_W-1:0]     out_idx_reg;
    logic [drtm_pkg::DR_W-1:0]          out_dr_reg;
    logic                               out_full_reg;

    // Control.
    drtm_pkg::op_t                      req_op;
    logic                               req_ready;
    logic                               req_fire;
    logic                               issue_en;
    logic                               pipe_busy;
    logic                               result_take;
    logic                               has_room;
    logic                               load_we;
    logic                               take_best;
    logic [drtm_pkg::DR_W-1:0]          best_dr_sat;

    // Stage one arithmetic.
    logic [drtm_pkg::ETA_W:0]           de, de_neg;
    logic [drtm_pkg::PHI_W-1:0]         dp, dp_neg;

    assign req_op   = drtm_pkg::op_t'(req.op);
    assign req_fire = req.valid && req_ready;
    assign has_room = (ref_count_reg < drtm_pkg::CNT_W'(drtm_pkg::MAX_OBJECTS));
    assign load_we  = req_fire && (req_op == drtm_pkg::OP_LOAD) && has_room;
    assign pipe_busy = s1_v_reg || s2_v_reg || s3_v_reg || s4_v_reg;

    // Outputs of the sequencer.
    always_comb
    begin
        req_ready   = 1'b0;
        issue_en    = 1'b0;
        result_take = 1'b0;
        case (state_reg)
            drtm_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
            end
            drtm_pkg::ST_SCAN:
            begin
                issue_en = (issue_idx_reg < ref_count_reg);
            end
            drtm_pkg::ST_RESULT:
            begin
                result_take = !out_valid_reg || rsp.ready;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            drtm_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (req_op == drtm_pkg::OP_QUERY)
                    begin
                        state_next = drtm_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = drtm_pkg::ST_RESULT;
                    end
                end
            end
            drtm_pkg::ST_SCAN:
            begin
                // All slots issued and the last one has left the pipeline.
                if (!issue_en && !pipe_busy)
                begin
                    state_next = drtm_pkg::ST_RESULT;
                end
            end
            drtm_pkg::ST_RESULT:
            begin
                if (result_take)
                begin
                    state_next = drtm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = drtm_pkg::ST_IDLE;
            end
        endcase
    end

    // Configuration writes.
    assign cfg.ready = 1'b1;

    always_comb
    begin
        max_dr_sq_next   = max_dr_sq_reg;
        max_rel_dpt_next = max_rel_dpt_reg;
        if (cfg.valid)
        begin
            case (drtm_pkg::cfg_reg_t'(cfg.index))
                drtm_pkg::REG_MAX_DR_SQ:
                begin
                    max_dr_sq_next = cfg.data[drtm_pkg::DR_W-1:0];
                end
                drtm_pkg::REG_MAX_REL_DPT:
                begin
                    max_rel_dpt_next = cfg.data[drtm_pkg::REL_W-1:0];
                end
                default:
                begin
                    max_dr_sq_next = max_dr_sq_reg;
                end
            endcase
        end
    end

    // Table fill count and scan address.
    always_comb
    begin
        ref_count_next = ref_count_reg;
        if (load_we)
        begin
            ref_count_next = ref_count_reg + 1'b1;
        end
        else if (req_fire && (req_op == drtm_pkg::OP_CLEAR))
        begin
            ref_count_next = '0;
        end

        issue_idx_next = issue_idx_reg;
        if (req_fire)
        begin
            issue_idx_next = '0;
        end
        else if (issue_en)
        begin
            issue_idx_next = issue_idx_reg + 1'b1;
        end
    end

    // Stage one: absolute differences against the entry just read.
    always_comb
    begin
        de     = {q_eta_reg[drtm_pkg::ETA_W-1], q_eta_reg}
               - {rd_data_reg.eta[drtm_pkg::ETA_W-1], rd_data_reg.eta};
        de_neg = ~de + 1'b1;
        s2_ade_next = de[drtm_pkg::ETA_W] ? de_neg[drtm_pkg::ETA_W-1:0]
                                          : de[drtm_pkg::ETA_W-1:0];

        // The phi difference wraps around the full circle; half a turn stays positive.
        dp     = q_phi_reg - rd_data_reg.phi;
        dp_neg = ~dp + 1'b1;
        s2_adp_next = dp[drtm_pkg::PHI_W-1] ? dp_neg : dp;

        s2_dpt_next = (q_pt_reg > rd_data_reg.pt) ? (q_pt_reg - rd_data_reg.pt)
                                                  : (rd_data_reg.pt - q_pt_reg);
    end

    // Stage two: the squares and the scaled pt limit, one multiplier on each path.
    always_comb
    begin
        s3_ade_sq_next = drtm_pkg::ADE_SQ_W'(s2_ade_reg) * drtm_pkg::ADE_SQ_W'(s2_ade_reg);
        s3_adp_sq_next = drtm_pkg::ADP_SQ_W'(s2_adp_reg) * drtm_pkg::ADP_SQ_W'(s2_adp_reg);
        s3_lim_next    = drtm_pkg::LIM_W'(max_rel_dpt_reg) * drtm_pkg::LIM_W'(s2_rp_reg);
        s3_dpt16_next  = {s2_dpt_reg, 4'b0000};
    end

    // Stage three: distance sum and both cuts. A zero reference pt gives a zero limit,
    // which no difference can stay below.
    always_comb
    begin
        s4_dr_next = drtm_pkg::DR_SUM_W'(s3_ade_sq_reg) + drtm_pkg::DR_SUM_W'(s3_adp_sq_reg);
        s4_ok_next = (drtm_pkg::LIM_W'(s3_dpt16_reg) < s3_lim_reg)
                  && (s4_dr_next < drtm_pkg::DR_SUM_W'(max_dr_sq_reg));
    end

    // Stage four: keep the strictly smaller distance, so the earlier slot wins a tie.
    assign take_best = s4_v_reg && s4_ok_reg && (!found_reg || (s4_dr_reg < best_dr_reg));

    always_comb
    begin
        found_next    = found_reg;
        best_idx_next = best_idx_reg;
        best_dr_next  = best_dr_reg;
        full_next     = full_reg;
        if (req_fire)
        begin
            found_next    = 1'b0;
            best_idx_next = '0;
            best_dr_next  = '0;
            full_next     = (req_op == drtm_pkg::OP_LOAD) && !has_room;
        end
        else if (take_best)
        begin
            found_next    = 1'b1;
            best_idx_next = s4_idx_reg;
            best_dr_next  = s4_dr_reg;
        end
    end

    assign best_dr_sat = (|best_dr_reg[drtm_pkg::DR_SUM_W-1:drtm_pkg::DR_W])
                       ? {drtm_pkg::DR_W{1'b1}} : best_dr_reg[drtm_pkg::DR_W-1:0];

    assign out_valid_next = result_take ? 1'b1 : (out_valid_reg && !rsp.ready);

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= drtm_pkg::ST_IDLE;
            max_dr_sq_reg   <= drtm_pkg::RESET_MAX_DR_SQ;
            max_rel_dpt_reg <= drtm_pkg::RESET_MAX_REL_DPT;
            ref_count_reg   <= '0;
            issue_idx_reg   <= '0;
            s1_v_reg        <= 1'b0;
            s2_v_reg        <= 1'b0;
            s3_v_reg        <= 1'b0;
            s4_v_reg        <= 1'b0;
            found_reg       <= 1'b0;
            full_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            max_dr_sq_reg   <= max_dr_sq_next;
            max_rel_dpt_reg <= max_rel_dpt_next;
            ref_count_reg   <= ref_count_next;
            issue_idx_reg   <= issue_idx_next;
            s1_v_reg        <= issue_en;
            s2_v_reg        <= s1_v_reg;
            s3_v_reg        <= s2_v_reg;
            s4_v_reg        <= s3_v_reg;
            found_reg       <= found_next;
            full_reg        <= full_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            q_pt_reg  <= req.pt;
            q_eta_reg <= req.eta;
            q_phi_reg <= req.phi;
        end
        s1_idx_reg    <= issue_idx_reg[drtm_pkg::IDX_W-1:0];
        s2_idx_reg    <= s1_idx_reg;
        s3_idx_reg    <= s2_idx_reg;
        s4_idx_reg    <= s3_idx_reg;
        s2_ade_reg    <= s2_ade_next;
        s2_adp_reg    <= s2_adp_next;
        s2_dpt_reg    <= s2_dpt_next;
        s2_rp_reg     <= rd_data_reg.pt;
        s3_ade_sq_reg <= s3_ade_sq_next;
        s3_adp_sq_reg <= s3_adp_sq_next;
        s3_dpt16_reg  <= s3_dpt16_next;
        s3_lim_reg    <= s3_lim_next;
        s4_dr_reg     <= s4_dr_next;
        s4_ok_reg     <= s4_ok_next;
        best_idx_reg  <= best_idx_next;
        best_dr_reg   <= best_dr_next;
        if (result_take)
        begin
            out_matched_reg <= found_reg;
            out_idx_reg     <= drtm_pkg::to_match_index(best_idx_reg);
            out_dr_reg      <= best_dr_sat;
            out_full_reg    <= full_reg;
        end
    end

    // Reference table: one write port for loads, one registered read port for the scan.
    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            mem[ref_count_reg[drtm_pkg::IDX_W-1:0]] <= '{pt: req.pt, eta: req.eta, phi: req.phi};
        end
        if (issue_en)
        begin
            rd_data_reg <= mem[issue_idx_reg[drtm_pkg::IDX_W-1:0]];
        end
    end

    assign req.ready       = req_ready;
    assign rsp.valid       = out_valid_reg;
    assign rsp.matched     = out_matched_reg;
    assign rsp.match_index = out_idx_reg;
    assign rsp.match_dr_sq = out_dr_reg;
    assign rsp.table_full  = out_full_reg;

`ifndef SYNTHESIS
    // The fill count never exceeds the table size.
    assert property (@(posedge clk) disable iff (!rst_n)
        ref_count_reg <= drtm_pkg::CNT_W'(drtm_pkg::MAX_OBJECTS))
        else $error("reference count beyond table size");

    // A new request is only taken once the scan pipeline has drained.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_ready |-> !pipe_busy)
        else $error("request taken while scan pipeline busy");

    // The scan never issues past the fill count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == drtm_pkg::ST_SCAN) |-> (issue_idx_reg <= ref_count_reg))
        else $error("scan address past fill count");

    // A response beat appears only after the result state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == drtm_pkg::ST_RESULT))
        else $error("response raised outside result state");

    // A match and a rejected load never come in the same beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_matched_reg) |-> !out_full_reg)
        else $error("match reported together with full table");
`endif

endmodule

@@ dv/delta_r_match_checker.sv @@
`timescale 1ns / 1ps

module delta_r_match_checker (
    input  logic clk,
    input  logic rst_n,
    drtm_cfg_if  cfg,
    drtm_in_if   req,
    drtm_out_if  rsp,
    output int   fail_count,
    output int   results_due
);

    localparam int PRINT_CAP = 200;

    typedef struct packed {
        logic                           matched;
        logic [drtm_pkg::OUT_IDX_W-1:0] match_index;
        logic [drtm_pkg::DR_W-1:0]      match_dr_sq;
        logic                           table_full;
    } match_result_t;

    // Shadow copy of the reference table and of the two cut registers.
    logic [drtm_pkg::PT_W-1:0]  tbl_pt  [drtm_pkg::MAX_OBJECTS];
    logic [drtm_pkg::ETA_W-1:0] tbl_eta [drtm_pkg::MAX_OBJECTS];
    logic [drtm_pkg::PHI_W-1:0] tbl_phi [drtm_pkg::MAX_OBJECTS];
    int unsigned                tbl_count;
    logic [drtm_pkg::DR_W-1:0]  dr_limit;
    logic [drtm_pkg::REL_W-1:0] pt_tol;

    match_result_t    match_results_q[$];
    int               beat_count;

    initial begin
        fail_count  = 0;
        results_due = 0;
        beat_count  = 0;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (fail_count < PRINT_CAP)
            $display("MISMATCH at result beat %0d: %s got 0x%0h, expected 0x%0h",
                     beat_count, what, got, want);
        fail_count++;
    endtask

    // Squared angular distance; the phi difference wraps modulo 2^16.
    function automatic logic [63:0] angular_dist_sq(
        input logic [drtm_pkg::ETA_W-1:0] eta_a,
        input logic [drtm_pkg::PHI_W-1:0] phi_a,
        input logic [drtm_pkg::ETA_W-1:0] eta_b,
        input logic [drtm_pkg::PHI_W-1:0] phi_b);
        logic signed [drtm_pkg::ETA_W:0] de;
        logic [drtm_pkg::ETA_W-1:0]      ade;
        logic [drtm_pkg::PHI_W-1:0]      dp;
        logic [drtm_pkg::PHI_W:0]        adp;
        de  = $signed({eta_a[drtm_pkg::ETA_W-1], eta_a})
            - $signed({eta_b[drtm_pkg::ETA_W-1], eta_b});
        ade = de[drtm_pkg::ETA_W] ? drtm_pkg::ETA_W'(-de) : drtm_pkg::ETA_W'(de);
        dp  = phi_a - phi_b;
        adp = dp[drtm_pkg::PHI_W-1] ? ({1'b1, {drtm_pkg::PHI_W{1'b0}}} - {1'b0, dp})
                                    : {1'b0, dp};
        return 64'(ade) * 64'(ade) + 64'(adp) * 64'(adp);
    endfunction

    function automatic match_result_t predict_match(
        input logic [drtm_pkg::OP_W-1:0]  op,
        input logic [drtm_pkg::PT_W-1:0]  pt,
        input logic [drtm_pkg::ETA_W-1:0] eta,
        input logic [drtm_pkg::PHI_W-1:0] phi);
        match_result_t              res;
        logic [63:0]                dpt;
        logic [63:0]                cand_dr;
        logic [63:0]                best;
        logic                       found;
        logic [drtm_pkg::IDX_W-1:0] slot;
        res   = '0;
        found = 1'b0;
        best  = '0;
        case (op)
            drtm_pkg::OP_LOAD:
            begin
                if (tbl_count >= drtm_pkg::MAX_OBJECTS)
                begin
                    res.table_full = 1'b1;
                end
                else
                begin
                    slot          = drtm_pkg::IDX_W'(tbl_count);
                    tbl_pt[slot]  = pt;
                    tbl_eta[slot] = eta;
                    tbl_phi[slot] = phi;
                    tbl_count++;
                end
            end
            drtm_pkg::OP_QUERY:
            begin
                for (int i = 0; i < tbl_count; i++)
                begin
                    slot = drtm_pkg::IDX_W'(i);
                    dpt = (pt > tbl_pt[slot]) ? 64'(pt - tbl_pt[slot])
                                              : 64'(tbl_pt[slot] - pt);
                    if ((dpt << 4) < 64'(pt_tol) * 64'(tbl_pt[slot]))
                    begin
                        cand_dr = angular_dist_sq(eta, phi, tbl_eta[slot], tbl_phi[slot]);
                        if (cand_dr < 64'(dr_limit) && (!found || cand_dr < best))
                        begin
                            found = 1'b1;
                            best  = cand_dr;
                            res.match_index = drtm_pkg::OUT_IDX_W'(i);
                        end
                    end
                end
                if (found)
                begin
                    res.matched     = 1'b1;
                    res.match_dr_sq = (best > 64'hFFFF_FFFF) ? '1
                                                             : best[drtm_pkg::DR_W-1:0];
                end
            end
            drtm_pkg::OP_CLEAR:
            begin
                tbl_count = 0;
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        match_result_t due;
        if (!rst_n)
        begin
            tbl_count = 0;
            dr_limit  = drtm_pkg::RESET_MAX_DR_SQ;
            pt_tol    = drtm_pkg::RESET_MAX_REL_DPT;
            match_results_q.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    drtm_pkg::REG_MAX_DR_SQ:   dr_limit = cfg.data;
                    drtm_pkg::REG_MAX_REL_DPT: pt_tol   = cfg.data[drtm_pkg::REL_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (rsp.valid && rsp.ready)
            begin
                if (match_results_q.size() == 0)
                begin
                    report_mismatch("result beat with no request waiting", 64'd1, 64'd0);
                end
                else
                begin
                    due = match_results_q.pop_front();
                    if (rsp.matched !== due.matched)
                        report_mismatch("matched", 64'(rsp.matched), 64'(due.matched));
                    if (rsp.match_index !== due.match_index)
                        report_mismatch("match_index", 64'(rsp.match_index),
                                        64'(due.match_index));
                    if (rsp.match_dr_sq !== due.match_dr_sq)
                        report_mismatch("match_dr_sq", 64'(rsp.match_dr_sq),
                                        64'(due.match_dr_sq));
                    if (rsp.table_full !== due.table_full)
                        report_mismatch("table_full", 64'(rsp.table_full),
                                        64'(due.table_full));
                end
                beat_count++;
            end
            if (req.valid && req.ready)
                match_results_q = {match_results_q,
                                   predict_match(req.op, req.pt, req.eta, req.phi)};
        end
        results_due = match_results_q.size();
    end

endmodule

@@ dv/delta_r_trigger_match_unit_test.sv @@
`timescale 1ns / 1ps

module delta_r_trigger_match_unit_test;

    // The op code the block leaves unused; it must still answer with an all-zero beat.
    localparam logic [drtm_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    // A query scans at most MAX_OBJECTS slots. Even with every beat
    // waiting out random stalls on both sides, 2000 items stay far below the limit.
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int RSP_HOLD_CYCLES = 400;
    localparam int RANDOM_ITEMS    = 2000;
    localparam int PHASES          = 6;
    localparam int DRAIN_CYCLES    = 2 * drtm_pkg::MAX_OBJECTS + 16;
    localparam int IDLE_PERCENT    = 34;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    drtm_cfg_if cfg_if ();
    drtm_in_if  req_if ();
    drtm_out_if rsp_if ();

    int fail_count;
    int results_due;

    // Knobs shared between the stimulus thread and the response-side thread.
    logic tx_idle_on = 1'b1;
    logic rx_idle_on = 1'b1;
    int   hold_asks  = 0;
    int   hold_seen  = 0;
    int   hold_left  = 0;

    int   items_sent   = 0;
    int   cycle_count  = 0;

    delta_r_trigger_match_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_if),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    delta_r_match_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_if),
        .req         (req_if),
        .rsp         (rsp_if),
        .fail_count  (fail_count),
        .results_due (results_due)
    );

    always #1 clk = ~clk;

    // Every input of the block is known from time zero.
    initial
    begin
        cfg_if.valid = 1'b0;
        cfg_if.index = drtm_pkg::REG_MAX_DR_SQ;
        cfg_if.data  = '0;
        req_if.valid = 1'b0;
        req_if.op    = drtm_pkg::OP_LOAD;
        req_if.pt    = '0;
        req_if.eta   = '0;
        req_if.phi   = '0;
        rsp_if.ready = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("delta_r_trigger_match_unit test failed");
            $finish;
        end
    end

    // Response side. Ready is random while idling is enabled and solid high
    // otherwise. When the stimulus asks for a hold-off, ready stays low for a
    // long counted stretch so that the block backs up and stalls its request port.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left    <= hold_left - 1;
            rsp_if.ready <= 1'b0;
        end
        else if (hold_asks != hold_seen)
        begin
            hold_seen    <= hold_asks;
            hold_left    <= RSP_HOLD_CYCLES;
            rsp_if.ready <= 1'b0;
        end
        else if (rx_idle_on)
        begin
            rsp_if.ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
        else
        begin
            rsp_if.ready <= 1'b1;
        end
    end

    // Offers one request beat and returns right after the edge that accepts it.
    // Valid is left high on return; the next call either lowers it for an idle
    // gap or simply puts new content on the bus, so valid never gets two
    // updates at the same edge.
    task automatic send_item(input logic [drtm_pkg::OP_W-1:0]  op,
                             input logic [drtm_pkg::PT_W-1:0]  pt,
                             input logic [drtm_pkg::ETA_W-1:0] eta,
                             input logic [drtm_pkg::PHI_W-1:0] phi);
        @(negedge clk);
        while (tx_idle_on && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            req_if.valid <= 1'b0;
            @(negedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.op    <= op;
        req_if.pt    <= pt;
        req_if.eta   <= eta;
        req_if.phi   <= phi;
        do
            @(posedge clk);
        while (!(req_if.valid && req_if.ready));
        if (op != OP_UNUSED)
            items_sent++;
    endtask

    // Register writes happen only with the block idle, which is the case once
    // every expected result beat has come back.
    task automatic write_reg(input drtm_pkg::cfg_reg_t idx,
                             input logic [drtm_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do
            @(posedge clk);
        while (!(cfg_if.valid && cfg_if.ready));
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Stops offering requests and waits until the checker holds no expectation.
    task automatic wait_results_drained();
        @(negedge clk);
        req_if.valid <= 1'b0;
        while (results_due != 0)
            @(negedge clk);
    endtask

    // Mostly random pt, with the two ends of the range mixed in so that the
    // zero-pt and full-scale cases keep showing up.
    function automatic logic [drtm_pkg::PT_W-1:0] pick_pt();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return drtm_pkg::PT_W'($urandom);
        endcase
    endfunction

    // One stimulus sequence. Most sequences are well formed: clear the table,
    // load a batch of references and then query tracks placed close to them,
    // so that the scan really finds and ranks candidates. Some skip the clear
    // and append to whatever the table holds, and a few are plain noise with
    // random ops, the unused op included.
    task automatic run_sequence();
        drtm_pkg::entry_t             loaded[$];
        drtm_pkg::entry_t             ref_obj;
        int                           mode;
        int                           n_loads;
        int                           n_queries;
        int                           spread;
        int                           off;
        int                           qpt;
        logic [drtm_pkg::ETA_W-1:0]   qeta;
        logic [drtm_pkg::PHI_W-1:0]   qphi;
        mode = $urandom_range(0, 9);
        if (mode == 0)
        begin
            repeat ($urandom_range(1, 8))
                send_item(drtm_pkg::OP_W'($urandom_range(0, 3)), drtm_pkg::PT_W'($urandom),
                          drtm_pkg::ETA_W'($urandom), drtm_pkg::PHI_W'($urandom));
        end
        else
        begin
            if (mode != 1)
                send_item(drtm_pkg::OP_CLEAR, drtm_pkg::PT_W'($urandom),
                          drtm_pkg::ETA_W'($urandom), drtm_pkg::PHI_W'($urandom));

            // Now and then fill the table past its capacity to see loads rejected.
            n_loads = ($urandom_range(0, 3) == 0)
                      ? $urandom_range(60, drtm_pkg::MAX_OBJECTS + 4)
                      : $urandom_range(0, 16);
            repeat (n_loads)
            begin
                if (loaded.size() > 0 && $urandom_range(0, 7) == 0)
                begin
                    // A duplicate entry gives equal distances, so the lower slot must win.
                    ref_obj = loaded[$urandom_range(0, loaded.size() - 1)];
                end
                else
                begin
                    ref_obj.pt  = pick_pt();
                    ref_obj.eta = drtm_pkg::ETA_W'($urandom);
                    // Some references sit right at the phi seam to exercise the wrap.
                    ref_obj.phi = ($urandom_range(0, 5) == 0)
                                  ? drtm_pkg::PHI_W'(32768 + int'($urandom_range(0, 64)) - 32)
                                  : drtm_pkg::PHI_W'($urandom);
                end
                send_item(drtm_pkg::OP_LOAD, ref_obj.pt, ref_obj.eta, ref_obj.phi);
                loaded = {loaded, ref_obj};
            end

            n_queries = $urandom_range(1, 12);
            repeat (n_queries)
            begin
                if (loaded.size() == 0 || $urandom_range(0, 5) == 0)
                begin
                    send_item(drtm_pkg::OP_QUERY, pick_pt(), drtm_pkg::ETA_W'($urandom),
                              drtm_pkg::PHI_W'($urandom));
                end
                else
                begin
                    // Place the track near a loaded reference, at a random scale so
                    // that the distance lands on either side of the limit.
                    ref_obj = loaded[$urandom_range(0, loaded.size() - 1)];
                    spread  = 1 << (3 * $urandom_range(0, 4));
                    off     = int'($urandom_range(0, 2 * spread)) - spread;
                    qeta    = ref_obj.eta + drtm_pkg::ETA_W'(off);
                    off     = int'($urandom_range(0, 2 * spread)) - spread;
                    qphi    = ref_obj.phi + drtm_pkg::PHI_W'(off);
                    qpt     = int'(ref_obj.pt) +
                              ((int'($urandom_range(0, 512)) - 256) * int'(ref_obj.pt)) / 64;
                    if (qpt < 0)
                        qpt = 0;
                    if (qpt > 65535)
                        qpt = 65535;
                    send_item(drtm_pkg::OP_QUERY, drtm_pkg::PT_W'(qpt), qeta, qphi);
                end
            end
        end
    endtask

    initial
    begin
        int directed_items;
        int target;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, run with the reset values of both registers.
        // A query on an empty table finds nothing.
        send_item(drtm_pkg::OP_QUERY, 16'd100, 17'h00000, 16'h0000);
        // A reference with zero pt can never pass the pt cut.
        send_item(drtm_pkg::OP_LOAD,  16'd0,   17'h00000, 16'h0000);
        send_item(drtm_pkg::OP_QUERY, 16'd0,   17'h00000, 16'h0000);
        // Field extremes: full-scale pt, largest eta and phi, then the most negative.
        send_item(drtm_pkg::OP_LOAD,  16'hFFFF, 17'h0FFFF, 16'h7FFF);
        send_item(drtm_pkg::OP_LOAD,  16'd1000, 17'h10000, 16'h8000);
        send_item(drtm_pkg::OP_QUERY, 16'hFFFF, 17'h0FFFF, 16'h7FFF);
        // Phi +pi against -pi is one unit apart once the difference wraps.
        send_item(drtm_pkg::OP_QUERY, 16'd1000, 17'h10000, 16'h7FFF);
        // A copy of slot 2 ties with it, and the lower slot is kept.
        send_item(drtm_pkg::OP_LOAD,  16'd1000, 17'h10000, 16'h8000);
        send_item(drtm_pkg::OP_QUERY, 16'd1000, 17'h10000, 16'h8000);
        // The unused op is ignored.
        send_item(OP_UNUSED, 16'hFFFF, 17'h1FFFF, 16'hFFFF);
        // The pt cut right at its edge: a difference of 2000 on 1000 fails, 1999 passes.
        send_item(drtm_pkg::OP_QUERY, 16'd3000, 17'h10000, 16'h8000);
        send_item(drtm_pkg::OP_QUERY, 16'd2999, 17'h10000, 16'h8000);
        // The distance cut at its edge: 104^2 passes and 105^2 does not.
        send_item(drtm_pkg::OP_QUERY, 16'd1000, 17'h10000, 16'h8068);
        send_item(drtm_pkg::OP_QUERY, 16'd1000, 17'h10000, 16'h8069);
        // Clear empties the table, and loading starts again at slot 0.
        send_item(drtm_pkg::OP_CLEAR, 16'hFFFF, 17'h1FFFF, 16'hFFFF);
        send_item(drtm_pkg::OP_QUERY, 16'd1000, 17'h10000, 16'h8000);
        send_item(drtm_pkg::OP_LOAD,  16'd500,  17'h00000, 16'h0000);
        send_item(drtm_pkg::OP_QUERY, 16'd510,  17'h00003, 16'hFFFE);
        directed_items = items_sent;

        // Random part, split into phases with different register settings.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_results_drained();
            case (phase)
                1:
                begin
                    // Widest cuts: both limits set to their largest values.
                    write_reg(drtm_pkg::REG_MAX_DR_SQ,   32'hFFFF_FFFF);
                    write_reg(drtm_pkg::REG_MAX_REL_DPT, 32'(12'hFFF));
                end
                2:
                begin
                    // Zero limits: nothing can ever match.
                    write_reg(drtm_pkg::REG_MAX_DR_SQ,   32'd0);
                    write_reg(drtm_pkg::REG_MAX_REL_DPT, 32'd0);
                end
                3:
                begin
                    // Tightest usable cuts: only exact positions match.
                    write_reg(drtm_pkg::REG_MAX_DR_SQ,   32'd1);
                    write_reg(drtm_pkg::REG_MAX_REL_DPT, 32'd1);
                end
                4:
                begin
                    write_reg(drtm_pkg::REG_MAX_DR_SQ,   32'($urandom_range(1000, 4000000)));
                    write_reg(drtm_pkg::REG_MAX_REL_DPT, 32'($urandom_range(1, 4095)));
                end
                5:
                begin
                    write_reg(drtm_pkg::REG_MAX_DR_SQ,   32'(drtm_pkg::RESET_MAX_DR_SQ));
                    write_reg(drtm_pkg::REG_MAX_REL_DPT, 32'(drtm_pkg::RESET_MAX_REL_DPT));
                end
                default:
                begin
                end
            endcase

            // Phase 4 is the stretch where neither side ever idles.
            tx_idle_on = (phase != 4);
            rx_idle_on = (phase != 4);
            // In phase 1 the response side holds off for a long while as the
            // requests keep coming.
            if (phase == 1)
                hold_asks++;

            target = RANDOM_ITEMS * (phase + 1) / PHASES;
            while (items_sent - directed_items < target)
                run_sequence();
        end

        // Let every outstanding beat come back, then watch a while longer for
        // any stray result beat.
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0)
            $display("delta_r_trigger_match_unit test passed");
        else
            $display("delta_r_trigger_match_unit test failed");
        $finish;
    end

endmodule

@@ sim.f @@
src/drtm_pkg.sv
src/drtm_if.sv
src/delta_r_trigger_match_unit.sv
dv/delta_r_match_checker.sv
dv/delta_r_trigger_match_unit_test.sv
